@@ rtl/assert_macros.svh @@
// shared assertion macros for the display formatter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tdf_pkg.sv @@
`default_nettype none

package tdf_pkg;

	// field widths
	localparam int unsigned FUNC_W     = 3;
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned CHARS_W    = 24;
	localparam int unsigned GLYPH_W    = 6;
	localparam int unsigned STEP_W     = 8;
	localparam int unsigned NUM_W      = 7;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned BAR_W      = VALUE_W + 2;

	// mode codes
	localparam logic [FUNC_W-1:0] FUNC_DIRECT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_HYST   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLAMP  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_BAR    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_PLAIN  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_W_COUNT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONE_LEVEL = 2'd3;

	// glyph codes
	localparam logic [GLYPH_W-1:0] GLYPH_BLANK    = 6'd62;
	localparam logic [GLYPH_W-1:0] GLYPH_DASH     = 6'd63;
	localparam logic [GLYPH_W-1:0] GLYPH_LETTER_W = 6'd32;
	localparam logic [GLYPH_W-1:0] GLYPH_LETTER_C = 6'd12;

	// alarm strings with a number
	localparam logic [CHARS_W-1:0] PACK_W_N = 24'h572D6E;
	localparam logic [CHARS_W-1:0] PACK_C_N = 24'h432D6E;

	localparam logic signed [VALUE_W-1:0] CLAMP_VALUE = 16'sd100;
	localparam logic signed [VALUE_W-1:0] NUM_MAX     = 16'sd999;
	localparam logic signed [VALUE_W-1:0] NEG_MIN     = -16'sd99;

	typedef logic [GLYPH_W-1:0] glyph_t;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [VALUE_W-1:0] value;
		logic [CHARS_W-1:0]        alarm_one_chars;
		logic                      alarm_one_on;
		logic [CHARS_W-1:0]        alarm_two_chars;
		logic                      alarm_two_on;
		logic [CHARS_W-1:0]        alarm_three_chars;
		logic                      alarm_three_on;
	} item_t;

	typedef struct packed {
		glyph_t high;
		glyph_t mid;
		glyph_t low;
	} glyphs_t;

	typedef struct packed {
		glyphs_t                   glyphs;
		logic                      held_wr;
		logic signed [VALUE_W-1:0] held_new;
	} calc_t;

	typedef struct packed {
		logic   known;
		glyph_t glyph;
	} char_dec_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} digits2_t;

	// ascii character to glyph; unknown characters are flagged
	function automatic char_dec_t char_decode(input logic [7:0] ch);
		char_dec_t  res;
		logic [7:0] d;
		res.known = 1'b1;
		res.glyph = GLYPH_BLANK;
		d = 8'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			d = ch - 8'd48;
			res.glyph = d[GLYPH_W-1:0];
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			d = ch - 8'd55;
			res.glyph = d[GLYPH_W-1:0];
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			d = ch - 8'd61;
			res.glyph = d[GLYPH_W-1:0];
		end else if (ch == 8'h20) begin
			res.glyph = GLYPH_BLANK;
		end else if (ch == 8'h2D) begin
			res.glyph = GLYPH_DASH;
		end else begin
			res.known = 1'b0;
		end
		return res;
	endfunction

	// two low decimal digits of a 7-bit number, divide by ten via reciprocal
	function automatic digits2_t digits2(input logic [NUM_W-1:0] n);
		digits2_t         res;
		logic [14:0]      prod;
		logic [3:0]       q;
		logic [NUM_W-1:0] rem;
		prod = 15'(n) * 15'd205;
		q = prod[14:11];
		rem = n - NUM_W'(NUM_W'(q) * NUM_W'(10));
		res.ones = rem[3:0];
		res.tens = (q >= 4'd10) ? (q - 4'd10) : q;
		return res;
	endfunction

	// signed value to three glyphs
	function automatic glyphs_t number_glyphs(input logic signed [VALUE_W-1:0] v);
		glyphs_t            res;
		logic [9:0]         u;
		logic [15:0]        prod;
		logic [3:0]         h;
		logic [9:0]         r10;
		logic [VALUE_W-1:0] negv;
		digits2_t           d;
		u = v[9:0];
		prod = 16'(u) * 16'd41;
		h = prod[15:12];
		r10 = u - 10'(10'(h) * 10'd100);
		negv = -v;
		if (!v[VALUE_W-1] && v <= NUM_MAX) begin
			d = digits2(r10[NUM_W-1:0]);
			res.high = {2'b00, h};
			res.mid  = {2'b00, d.tens};
			res.low  = {2'b00, d.ones};
		end else if (v[VALUE_W-1] && v >= NEG_MIN) begin
			d = digits2(negv[NUM_W-1:0]);
			res.high = GLYPH_DASH;
			res.mid  = {2'b00, d.tens};
			res.low  = {2'b00, d.ones};
		end else begin
			res.high = GLYPH_DASH;
			res.mid  = GLYPH_DASH;
			res.low  = GLYPH_DASH;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tdf_in_reg.sv @@
`default_nettype none

module tdf_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire tdf_pkg::item_t item,
	input  wire logic          adv,
	output logic               in_stall,
	output logic               valid_s1,
	output tdf_pkg::item_t     item_s1
);
	import tdf_pkg::*;

	// hold the request while the stage cannot move on
	assign in_stall = valid_s1 && !adv;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tdf_glyph_calc.sv @@
`default_nettype none

module tdf_glyph_calc #(
	parameter int HYST_BAND = 4
) (
	input  wire tdf_pkg::item_t                         item,
	input  wire tdf_pkg::glyphs_t                       shown,
	input  wire logic signed [tdf_pkg::VALUE_W-1:0]     held,
	input  wire logic signed [tdf_pkg::VALUE_W-1:0]     bar_base,
	input  wire logic [tdf_pkg::STEP_W-1:0]             bar_step,
	input  wire logic [tdf_pkg::NUM_W-1:0]              w_count,
	input  wire logic [tdf_pkg::NUM_W-1:0]              cone_level,
	output tdf_pkg::calc_t                              calc
);
	import tdf_pkg::*;

	localparam int HYST_W = $clog2(HYST_BAND + 1) + 1;
	localparam int LOW_W  = VALUE_W + HYST_W + 1;

	logic signed [LOW_W-1:0]   held_x;
	logic signed [LOW_W-1:0]   value_x;
	logic signed [LOW_W-1:0]   low_bound;
	logic                      moved;
	logic signed [BAR_W-1:0]   value_b;
	logic signed [BAR_W-1:0]   base_b;
	logic signed [BAR_W-1:0]   step_b;
	logic signed [BAR_W-1:0]   lvl1;
	logic signed [BAR_W-1:0]   lvl2;
	logic                      above_base;
	logic                      over_clamp;
	logic signed [VALUE_W-1:0] hyst_num;
	logic signed [VALUE_W-1:0] disp_num;
	logic [CHARS_W-1:0]        str;
	logic                      use_str;
	char_dec_t                 dec_h;
	char_dec_t                 dec_m;
	char_dec_t                 dec_l;
	digits2_t                  ln;
	glyphs_t                   alarm_glyphs;

	// hysteresis window at full precision
	always_comb begin
		held_x    = LOW_W'(held);
		value_x   = LOW_W'(item.value);
		low_bound = held_x - LOW_W'(HYST_BAND);
		moved     = (item.value > held) || (value_x < low_bound);
		hyst_num  = moved ? item.value : held;
		over_clamp = item.value > CLAMP_VALUE;
	end

	// bar graph thresholds
	always_comb begin
		value_b    = BAR_W'(item.value);
		base_b     = BAR_W'(bar_base);
		step_b     = signed'(BAR_W'(bar_step));
		lvl1       = base_b + step_b;
		lvl2       = lvl1 + step_b;
		above_base = value_b > base_b;
	end

	// number that the alarm-aware path shows
	always_comb begin
		case (item.func)
			FUNC_DIRECT: disp_num = item.value;
			FUNC_CLAMP:  disp_num = over_clamp ? CLAMP_VALUE : hyst_num;
			default:     disp_num = hyst_num;
		endcase
	end

	// alarm priority: one, then three, then two
	always_comb begin
		use_str = 1'b1;
		str     = item.alarm_one_chars;
		ln      = digits2(w_count);
		alarm_glyphs = number_glyphs(disp_num);
		if (item.alarm_one_on) begin
			str = item.alarm_one_chars;
		end else if (item.alarm_three_on) begin
			str = item.alarm_three_chars;
			if (item.alarm_three_chars == PACK_W_N) begin
				use_str = 1'b0;
				ln = digits2(w_count);
				alarm_glyphs = '{high: GLYPH_LETTER_W, mid: {2'b00, ln.tens},
					low: {2'b00, ln.ones}};
			end else if (item.alarm_three_chars == PACK_C_N) begin
				use_str = 1'b0;
				ln = digits2(cone_level);
				alarm_glyphs = '{high: GLYPH_LETTER_C, mid: {2'b00, ln.tens},
					low: {2'b00, ln.ones}};
			end
		end else if (item.alarm_two_on) begin
			str = item.alarm_two_chars;
		end else begin
			use_str = 1'b0;
		end
		dec_h = char_decode(str[23:16]);
		dec_m = char_decode(str[15:8]);
		dec_l = char_decode(str[7:0]);
		// unknown characters keep the glyph already shown
		if (use_str) begin
			alarm_glyphs.high = dec_h.known ? dec_h.glyph : shown.high;
			alarm_glyphs.mid  = dec_m.known ? dec_m.glyph : shown.mid;
			alarm_glyphs.low  = dec_l.known ? dec_l.glyph : shown.low;
		end
	end

	// per-mode result and held value update
	always_comb begin
		calc.held_new = item.value;
		calc.held_wr  = 1'b0;
		calc.glyphs   = shown;
		case (item.func)
			FUNC_DIRECT: begin
				calc.glyphs = alarm_glyphs;
			end
			FUNC_HYST: begin
				calc.glyphs  = alarm_glyphs;
				calc.held_wr = moved;
			end
			FUNC_CLAMP: begin
				calc.glyphs  = alarm_glyphs;
				calc.held_wr = moved && !over_clamp;
			end
			FUNC_BAR: begin
				if (value_b > lvl2) begin
					calc.glyphs = '{high: GLYPH_DASH, mid: GLYPH_DASH, low: GLYPH_DASH};
				end else if (value_b > lvl1) begin
					calc.glyphs = '{high: GLYPH_DASH, mid: GLYPH_DASH, low: GLYPH_BLANK};
				end else if (above_base) begin
					calc.glyphs = '{high: GLYPH_DASH, mid: GLYPH_BLANK, low: GLYPH_BLANK};
				end else begin
					calc.glyphs  = alarm_glyphs;
					calc.held_wr = moved;
				end
			end
			FUNC_PLAIN: begin
				calc.glyphs = number_glyphs(item.value);
			end
			default: begin
				calc.glyphs = shown;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/tdf_out_reg.sv @@
`default_nettype none

module tdf_out_reg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               out_stall,
	input  wire tdf_pkg::calc_t                     calc,
	output logic                                    out_valid,
	output tdf_pkg::glyphs_t                        shown_q,
	output logic signed [tdf_pkg::VALUE_W-1:0]      held_q
);
	import tdf_pkg::*;

	// result valid: set on a new result, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// shown glyphs double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			held_q  <= '0;
		end else if (adv) begin
			shown_q <= calc.glyphs;
			if (calc.held_wr) begin
				held_q <= calc.held_new;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/three_digit_display_formatter.sv @@
// Three-digit display formatter.
// Input channel: in_valid / in_stall with func, value and three alarm strings.
// A request is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with glyph_high, glyph_mid, glyph_low.
// Configuration: cfg_wen, cfg_index, cfg_data; write only while idle.
// A request taken lands in the input register; its glyphs are loaded into
// the output register when the input stage moves on, and out_valid rises
// with that load.
// Throughput: one request per cycle while the output is not stalled. Glyph
// state and the held value update in the same edge that loads the output
// register, so the next request in the input register already sees them.
// A stalled output holds its glyphs; the input register keeps one request
// and in_stall rises only when both registers are full.
// Reset clears glyphs, held value, config registers and both valid flags.
`default_nettype none

module three_digit_display_formatter #(
	parameter int HYST_BAND = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wen,
	input  wire logic [tdf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [tdf_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [tdf_pkg::FUNC_W-1:0]            func,
	input  wire logic signed [tdf_pkg::VALUE_W-1:0]    value,
	input  wire logic [tdf_pkg::CHARS_W-1:0]           alarm_one_chars,
	input  wire logic                                  alarm_one_on,
	input  wire logic [tdf_pkg::CHARS_W-1:0]           alarm_two_chars,
	input  wire logic                                  alarm_two_on,
	input  wire logic [tdf_pkg::CHARS_W-1:0]           alarm_three_chars,
	input  wire logic                                  alarm_three_on,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [tdf_pkg::GLYPH_W-1:0]                glyph_high,
	output logic [tdf_pkg::GLYPH_W-1:0]                glyph_mid,
	output logic [tdf_pkg::GLYPH_W-1:0]                glyph_low
);
	import tdf_pkg::*;

	`include "assert_macros.svh"

	logic signed [VALUE_W-1:0] bar_base_q;
	logic [STEP_W-1:0]         bar_step_q;
	logic [NUM_W-1:0]          w_count_q;
	logic [NUM_W-1:0]          cone_level_q;
	item_t                     item_in;
	item_t                     item_s1;
	logic                      valid_s1;
	logic                      adv;
	calc_t                     calc;
	glyphs_t                   shown_q;
	logic signed [VALUE_W-1:0] held_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_base_q   <= '0;
			bar_step_q   <= '0;
			w_count_q    <= '0;
			cone_level_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_BAR_BASE:   bar_base_q   <= cfg_data;
				CFG_BAR_STEP:   bar_step_q   <= cfg_data[STEP_W-1:0];
				CFG_W_COUNT:    w_count_q    <= cfg_data[NUM_W-1:0];
				CFG_CONE_LEVEL: cone_level_q <= cfg_data[NUM_W-1:0];
				default:        bar_base_q   <= bar_base_q;
			endcase
		end
	end

	// gather the request fields
	assign item_in = '{func: func, value: value,
		alarm_one_chars: alarm_one_chars, alarm_one_on: alarm_one_on,
		alarm_two_chars: alarm_two_chars, alarm_two_on: alarm_two_on,
		alarm_three_chars: alarm_three_chars, alarm_three_on: alarm_three_on};

	// input stage moves on when the output register is free or being taken
	assign adv = valid_s1 && (!out_valid || !out_stall);

	tdf_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item_in),
		.adv      (adv),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tdf_glyph_calc #(
		.HYST_BAND (HYST_BAND)
	) u_glyph_calc (
		.item       (item_s1),
		.shown      (shown_q),
		.held       (held_q),
		.bar_base   (bar_base_q),
		.bar_step   (bar_step_q),
		.w_count    (w_count_q),
		.cone_level (cone_level_q),
		.calc       (calc)
	);

	tdf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.out_stall (out_stall),
		.calc      (calc),
		.out_valid (out_valid),
		.shown_q   (shown_q),
		.held_q    (held_q)
	);

	assign glyph_high = shown_q.high;
	assign glyph_mid  = shown_q.mid;
	assign glyph_low  = shown_q.low;

	// checks on the stage handoff and state updates
	`ASSERT_NEXT(a_adv_gives_result, clk, arst_n, adv, out_valid, "advance without result")
	`ASSERT_NEXT(a_held_only_on_adv, clk, arst_n, !adv, $stable(held_q), "held value moved while idle")
	`ASSERT_NEXT(a_unused_func_keeps, clk, arst_n, adv && (item_s1.func > FUNC_PLAIN), $stable(shown_q), "unused mode changed glyphs")
	`ASSERT_IMPL(a_free_out_no_stall, clk, arst_n, valid_s1 && !out_valid, !in_stall, "stall with free output")

endmodule

`default_nettype wire
